// File: rtl/oli_pkg.sv
`default_nettype none
package oli_pkg;

    localparam int ENTRY_W = 32;

    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_DELETE = 2'd2;
    localparam logic [1:0] KIND_FIND   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic [1:0]                kind;
        logic signed [ENTRY_W-1:0] value;
        logic [6:0]                position;
    } oli_req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] found_position;
        logic [6:0] count;
    } oli_rsp_t;

    typedef struct packed {
        logic load;
        logic take_left;
        logic take_right;
    } oli_cell_ctl_t;

endpackage
`default_nettype wire

// File: rtl/oli_cell.sv
`default_nettype none
module oli_cell (
    input  wire logic                        clk,
    input  wire oli_pkg::oli_cell_ctl_t      ctl,
    input  wire logic [oli_pkg::ENTRY_W-1:0] value,
    input  wire logic [oli_pkg::ENTRY_W-1:0] left,
    input  wire logic [oli_pkg::ENTRY_W-1:0] right,
    input  wire logic                        occupied,
    output logic [oli_pkg::ENTRY_W-1:0]      entry,
    output logic                             match
);
    import oli_pkg::*;

    logic [ENTRY_W-1:0] entry_reg;
    logic [ENTRY_W-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.load)
        begin
            entry_next = value;
        end
        else if (ctl.take_left)
        begin
            entry_next = left;
        end
        else if (ctl.take_right)
        begin
            entry_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign match = occupied && (entry_reg == value);

endmodule
`default_nettype wire

// File: rtl/oli_first.sv
`default_nettype none
module oli_first #(
    parameter int N  = 64,
    parameter int IW = 6
) (
    input  wire logic [N-1:0]  match,
    output logic               any,
    output logic [N-1:0]       seen,
    output logic [IW-1:0]      index
);
    localparam int LV = $clog2(N);

    logic [N-1:0] first;

    // inclusive prefix OR, log-depth
    always_comb
    begin
        seen = match;
        for (int l = 0; l < LV; l++)
        begin
            seen = seen | (seen << (1 << l));
        end
    end

    assign first = match & ~(seen << 1);
    assign any   = seen[N-1];

    always_comb
    begin
        index = '0;
        for (int i = 0; i < N; i++)
        begin
            if (first[i])
            begin
                index = index | IW'(i);
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/ordered_list_insert_delete_find_top.sv
`default_nettype none
// Bounded ordered list of signed 32-bit words held in a row of CAPACITY cells.
// Each request word (append, insert at position, delete by value, find by
// value) yields one response word. A request is first registered; then every
// cell compares its entry, a first-match network resolves the lowest matching
// position and the whole row shifts or loads in place. The next request is
// taken as soon as the response sits in the output register; its shift or
// load then waits while that register still holds an untaken word.
// found_position and count report the low 6 and 7 bits of the true values.
module ordered_list_insert_delete_find_top #(
    parameter int CAPACITY = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire oli_pkg::oli_req_t req,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output oli_pkg::oli_rsp_t      rsp
);
    import oli_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int PW = (CW > 7) ? CW : 7;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic              busy_reg;
    logic              busy_next;
    oli_req_t          req_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    oli_rsp_t          out_reg;
    oli_rsp_t          out_next;

    logic              accept;
    logic              finish;
    logic [PW-1:0]     count_ext;
    logic [PW-1:0]     pos_eff;
    logic              is_add;
    logic              range_err;
    logic              full;
    logic              add_ok;
    logic              del_ok;
    logic              any;
    logic [IW-1:0]     index;
    logic [31:0]       index_w;
    logic [31:0]       count_w;
    logic [CAPACITY-1:0] match;
    logic [CAPACITY-1:0] seen;
    logic [ENTRY_W-1:0]  entry [CAPACITY];

    assign accept    = req_valid && !busy_reg;
    assign req_stall = busy_reg;
    assign finish    = busy_reg && (!out_valid_reg || !rsp_stall);

    assign count_ext = PW'(count_reg);
    assign is_add    = (req_reg.kind == KIND_APPEND) || (req_reg.kind == KIND_INSERT);
    assign pos_eff   = (req_reg.kind == KIND_APPEND) ? count_ext : PW'(req_reg.position);
    assign range_err = pos_eff > count_ext;
    assign full      = count_reg == CAP_C;
    assign add_ok    = is_add && !range_err && !full;
    assign del_ok    = (req_reg.kind == KIND_DELETE) && any;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            localparam logic [PW-1:0] IDX = PW'(g);
            oli_cell_ctl_t      ctl;
            logic [ENTRY_W-1:0] left;
            logic [ENTRY_W-1:0] right;

            assign ctl.load       = finish && add_ok && (IDX == pos_eff);
            assign ctl.take_left  = finish && add_ok && (IDX > pos_eff);
            assign ctl.take_right = finish && del_ok && seen[g];

            if (g == 0)
            begin : g_first
                assign left = req_reg.value;
            end
            else
            begin : g_mid
                assign left = entry[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_last
                assign right = entry[g];
            end
            else
            begin : g_inner
                assign right = entry[g+1];
            end

            oli_cell u_cell (
                .clk      (clk),
                .ctl      (ctl),
                .value    (req_reg.value),
                .left     (left),
                .right    (right),
                .occupied (IDX < count_ext),
                .entry    (entry[g]),
                .match    (match[g])
            );
        end
    endgenerate

    oli_first #(
        .N  (CAPACITY),
        .IW (IW)
    ) u_first (
        .match (match),
        .any   (any),
        .seen  (seen),
        .index (index)
    );

    always_comb
    begin
        count_next = count_reg;
        if (add_ok)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (del_ok)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    assign index_w = (!is_add && any) ? 32'(index) : 32'd0;
    assign count_w = 32'(count_next);

    always_comb
    begin
        if (is_add)
        begin
            out_next.status = range_err ? ST_RANGE : (full ? ST_FULL : ST_OK);
        end
        else
        begin
            out_next.status = any ? ST_OK : ST_MISSING;
        end
        out_next.found_position = index_w[5:0];
        out_next.count          = count_w[6:0];
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (finish)
        begin
            busy_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            if (finish)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (finish)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule
`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import oli_pkg::*;

    localparam int LIST_DEPTH = 64;
    localparam int RANDOM_WORDS = 950;
    localparam int STUCK_LIMIT = 2000;
    localparam int TAIL_CYCLES = 20;

    typedef struct {
        oli_req_t word;
        bit       typed;
        oli_rsp_t rsp;
    } plan_row_t;

    typedef enum logic [1:0] {GROW, SHRINK, CHURN} phase_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    oli_req_t req = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    oli_rsp_t rsp;

    logic signed [31:0] shadow_vals [LIST_DEPTH];
    int                 shadow_len = 0;
    oli_rsp_t           rsp_due_q [$];
    plan_row_t          plan [$];

    bit       calm = 1'b0;
    bit       row_typed = 1'b0;
    oli_rsp_t row_rsp = '0;
    int       mismatches = 0;
    int       words_taken = 0;
    int       status_tally [4];
    int       stuck_cycles = 0;
    logic     moved;
    oli_rsp_t want;

    ordered_list_insert_delete_find_top #(
        .CAPACITY(LIST_DEPTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic oli_rsp_t apply_request(input oli_req_t w);
        oli_rsp_t r;
        int spot;
        int hit;
        r = '0;
        r.status = ST_OK;
        hit = -1;
        if (w.kind == KIND_APPEND || w.kind == KIND_INSERT)
        begin
            spot = (w.kind == KIND_APPEND) ? shadow_len : int'(w.position);
            if (spot > shadow_len)
                r.status = ST_RANGE;
            else if (shadow_len >= LIST_DEPTH)
                r.status = ST_FULL;
            else
            begin
                for (int i = shadow_len; i > spot; i--)
                    shadow_vals[i] = shadow_vals[i - 1];
                shadow_vals[spot] = w.value;
                shadow_len++;
            end
        end
        else
        begin
            for (int i = 0; i < shadow_len; i++)
                if (hit < 0 && shadow_vals[i] == w.value)
                    hit = i;
            if (hit < 0)
                r.status = ST_MISSING;
            else
            begin
                r.found_position = 6'(hit);
                if (w.kind == KIND_DELETE)
                begin
                    for (int i = hit; i + 1 < shadow_len; i++)
                        shadow_vals[i] = shadow_vals[i + 1];
                    shadow_len--;
                end
            end
        end
        r.count = 7'(shadow_len);
        return r;
    endfunction

    function automatic plan_row_t mk(input logic [1:0] k, input logic [31:0] v, input int p,
                                     input bit t, input logic [1:0] s, input int f,
                                     input int c);
        plan_row_t row;
        row.word.kind = k;
        row.word.value = v;
        row.word.position = 7'(p);
        row.typed = t;
        row.rsp.status = s;
        row.rsp.found_position = 6'(f);
        row.rsp.count = 7'(c);
        return row;
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        int near;
        r = $urandom_range(0, 99);
        near = int'($urandom_range(0, 6)) - 3;
        if (r < 45 && shadow_len > 0)
            return shadow_vals[$urandom_range(0, shadow_len - 1)];
        if (r < 70)
            return near;
        if (r < 78)
            return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        return $urandom();
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_v);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, exp_v);
        mismatches++;
    endtask

    task automatic send_word(input oli_req_t w, input bit typed, input oli_rsp_t exp_rsp);
        if (!calm && $urandom_range(0, 99) < 31)
        begin
            req_valid = 1'b0;
            @(negedge clk);
            while ($urandom_range(0, 99) < 31)
                @(negedge clk);
        end
        req = w;
        row_typed = typed;
        row_rsp = exp_rsp;
        req_valid = 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    always @(negedge clk)
        rsp_stall = !calm && ($urandom_range(0, 99) < 31);

    always @(posedge clk)
    begin
        moved = 1'b0;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                moved = 1'b1;
                want = apply_request(req);
                if (row_typed)
                    want = row_rsp;
                rsp_due_q.push_back(want);
                words_taken++;
                status_tally[want.status]++;
            end
            if (rsp_valid && !rsp_stall)
            begin
                moved = 1'b1;
                if (rsp_due_q.size() == 0)
                    report_mismatch("unexpected word, status", rsp.status, 0);
                else
                begin
                    want = rsp_due_q.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch("status", rsp.status, want.status);
                    if (rsp.found_position !== want.found_position)
                        report_mismatch("found_position", rsp.found_position,
                                        want.found_position);
                    if (rsp.count !== want.count)
                        report_mismatch("count", rsp.count, want.count);
                end
            end
            stuck_cycles = moved ? 0 : stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles", STUCK_LIMIT);
                $display("FAIL ordered_list_insert_delete_find_top");
                $finish;
            end
        end
    end

    initial
    begin
        oli_req_t w;
        phase_t   phase;
        int       full_tries;
        int       r;

        plan.push_back(mk(KIND_FIND,   32'h0000_0000, 0,  1, ST_MISSING, 0, 0));
        plan.push_back(mk(KIND_DELETE, 32'h0000_0005, 64, 1, ST_MISSING, 0, 0));
        plan.push_back(mk(KIND_INSERT, 32'h0000_0009, 1,  1, ST_RANGE,   0, 0));
        plan.push_back(mk(KIND_INSERT, 32'h0000_0009, 64, 1, ST_RANGE,   0, 0));
        plan.push_back(mk(KIND_APPEND, 32'h7FFF_FFFF, 64, 1, ST_OK,      0, 1));
        plan.push_back(mk(KIND_APPEND, 32'h8000_0000, 0,  1, ST_OK,      0, 2));
        plan.push_back(mk(KIND_INSERT, 32'hFFFF_FFFF, 0,  1, ST_OK,      0, 3));
        plan.push_back(mk(KIND_INSERT, 32'h0000_0000, 3,  1, ST_OK,      0, 4));
        plan.push_back(mk(KIND_INSERT, 32'h0000_3039, 2,  0, ST_OK,      0, 0));
        plan.push_back(mk(KIND_FIND,   32'h8000_0000, 63, 0, ST_OK,      0, 0));
        plan.push_back(mk(KIND_FIND,   32'hFFFF_FFFF, 0,  1, ST_OK,      0, 5));
        plan.push_back(mk(KIND_APPEND, 32'hFFFF_FFFF, 0,  0, ST_OK,      0, 0));
        plan.push_back(mk(KIND_FIND,   32'hFFFF_FFFF, 0,  0, ST_OK,      0, 0));
        plan.push_back(mk(KIND_DELETE, 32'hFFFF_FFFF, 0,  0, ST_OK,      0, 0));
        plan.push_back(mk(KIND_FIND,   32'hFFFF_FFFF, 0,  0, ST_OK,      0, 0));
        plan.push_back(mk(KIND_DELETE, 32'h7FFF_FFFF, 0,  0, ST_OK,      0, 0));
        plan.push_back(mk(KIND_FIND,   32'h0000_002A, 0,  1, ST_MISSING, 0, 4));
        plan.push_back(mk(KIND_INSERT, 32'h0000_0001, 5,  1, ST_RANGE,   0, 4));
        plan.push_back(mk(KIND_INSERT, 32'h0000_0001, 64, 1, ST_RANGE,   0, 4));
        plan.push_back(mk(KIND_DELETE, 32'hFFFF_FFFF, 0,  0, ST_OK,      0, 0));
        plan.push_back(mk(KIND_INSERT, 32'h0000_0007, 1,  0, ST_OK,      0, 0));
        plan.push_back(mk(KIND_DELETE, 32'h0000_3039, 0,  0, ST_OK,      0, 0));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (plan[i])
            send_word(plan[i].word, plan[i].typed, plan[i].rsp);

        phase = GROW;
        full_tries = 0;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            calm = (n >= 400 && n < 550);
            if (shadow_len == LIST_DEPTH && ++full_tries > 4)
            begin
                phase = SHRINK;
                full_tries = 0;
            end
            else if (shadow_len == 0 && phase == SHRINK)
                phase = GROW;
            else if ($urandom_range(0, 99) < 2)
                phase = phase_t'($urandom_range(0, 2));

            r = $urandom_range(0, 99);
            case (phase)
                GROW:
                    w.kind = (r < 45) ? KIND_APPEND : (r < 85) ? KIND_INSERT :
                             (r < 93) ? KIND_DELETE : KIND_FIND;
                SHRINK:
                    w.kind = (r < 10) ? KIND_APPEND : (r < 20) ? KIND_INSERT :
                             (r < 70) ? KIND_DELETE : KIND_FIND;
                default:
                    w.kind = 2'($urandom_range(0, 3));
            endcase
            w.value = pick_value();
            r = $urandom_range(0, 99);
            if (w.kind == KIND_INSERT && r < 80)
                w.position = 7'($urandom_range(0, shadow_len));
            else if (w.kind == KIND_INSERT && r < 88)
                w.position = '0;
            else
                w.position = 7'($urandom_range(0, 64));
            send_word(w, 1'b0, '0);
        end
        calm = 1'b0;
        req_valid = 1'b0;

        while (rsp_due_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d request words checked: %0d ok, %0d full, %0d out of range, %0d not found",
                 words_taken, status_tally[ST_OK], status_tally[ST_FULL],
                 status_tally[ST_RANGE], status_tally[ST_MISSING]);
        $display("list filled and drained through empty and full; %0d mismatches", mismatches);
        if (mismatches == 0)
            $display("PASS ordered_list_insert_delete_find_top");
        else
            $display("FAIL ordered_list_insert_delete_find_top");
        $finish;
    end

endmodule

// File: filelist.f
rtl/oli_pkg.sv
rtl/oli_cell.sv
rtl/oli_first.sv
rtl/ordered_list_insert_delete_find_top.sv
bench/testbench.sv
